@@ design/ubdc_pkg.sv @@
// Shared types, constants and divider step functions for the baud divisor checker.
// No dependencies; imported by ubdc_err_check and uart_baud_divisor_calc.
`default_nettype none

package ubdc_pkg;

	localparam int BAUD_W  = 24;
	localparam int CLK_W   = 31;
	localparam int NUM_W   = CLK_W + 1;          // twice the module clock
	localparam int DEN_W   = 18;                 // 32 * divisor + adjust, divisor <= 0x1FFF
	localparam int FRAC_W  = 5;                  // adjust in thirty-seconds
	localparam int SBR_W   = NUM_W - FRAC_W;
	localparam int LIM_W   = 20;

	localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(120000000);
	localparam logic [SBR_W-1:0] DIV_MAX   = SBR_W'(13'h1FFF);

	// floor(b / 100) == (b * RECIP_100) >> RECIP_SHIFT for every 24-bit b
	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 31;
	localparam int PROD_W      = BAUD_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(21474837);

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_BAUD = 2'd1,
		ST_RANGE     = 2'd2,
		ST_ERROR     = 2'd3
	} status_t;

	typedef struct packed {
		logic [BAUD_W-1:0] baud;
		logic [NUM_W-1:0]  num;
	} pkt_t;

	typedef struct packed {
		logic zero_baud;
		logic range_bad;
	} flag_t;

	// one restoring step, divisor the requested rate: returns {quotient bit, remainder}
	function automatic logic [BAUD_W:0] div_step_a(input logic [BAUD_W-1:0] rem,
			input logic nbit, input logic [BAUD_W-1:0] den);
		logic [BAUD_W:0] trial;
		logic [BAUD_W:0] diff;
		trial = {rem, nbit};
		diff  = trial - {1'b0, den};
		if (trial >= {1'b0, den}) begin
			return {1'b1, diff[BAUD_W-1:0]};
		end else begin
			return {1'b0, trial[BAUD_W-1:0]};
		end
	endfunction

	// one restoring step, divisor 32 * SBR + BRFA
	function automatic logic [DEN_W:0] div_step_b(input logic [DEN_W-1:0] rem,
			input logic nbit, input logic [DEN_W-1:0] den);
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		trial = {rem, nbit};
		diff  = trial - {1'b0, den};
		if (trial >= {1'b0, den}) begin
			return {1'b1, diff[DEN_W-1:0]};
		end else begin
			return {1'b0, trial[DEN_W-1:0]};
		end
	endfunction

endpackage

`default_nettype wire

@@ design/ubdc_err_check.sv @@
// Last two pipeline stages: error of the achieved rate against the 3 % limit, and status.
// Depends on ubdc_pkg.
`default_nettype none

module ubdc_err_check
	import ubdc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [BAUD_W-1:0] baud,
	input  wire logic [NUM_W-1:0]  achieved,
	input  wire flag_t             flags,
	output status_t                status
);

	logic [NUM_W-1:0]  diff_s1;
	logic [PROD_W-1:0] prod_s1;
	flag_t             flags_s1;
	status_t           status_s2;

	logic [NUM_W-1:0]  diff_d;
	logic [PROD_W-1:0] prod_d;
	logic [DEN_W-1:0]  per_cent;
	logic [LIM_W-1:0]  limit;
	status_t           status_d;

	always_comb begin
		if (achieved > NUM_W'(baud)) begin
			diff_d = achieved - NUM_W'(baud);
		end else begin
			diff_d = NUM_W'(baud) - achieved;
		end
		prod_d = PROD_W'(baud) * PROD_W'(RECIP_100);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1  <= diff_d;
			prod_s1  <= prod_d;
			flags_s1 <= flags;
		end
	end

	always_comb begin
		per_cent = prod_s1[RECIP_SHIFT +: DEN_W];
		limit    = {LIM_W'(per_cent) << 1} + LIM_W'(per_cent);
		if (flags_s1.zero_baud) begin
			status_d = ST_ZERO_BAUD;
		end else if (flags_s1.range_bad) begin
			status_d = ST_RANGE;
		end else if (diff_s1 > NUM_W'(limit)) begin
			status_d = ST_ERROR;
		end else begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s2 <= status_d;
		end
	end

	assign status = status_s2;

endmodule

`default_nettype wire

@@ design/uart_baud_divisor_calc.sv @@
// Baud divisor checker: top level with the two pipelined restoring dividers.
// Depends on ubdc_pkg and ubdc_err_check.
//
// Usage
//   cfg_we/cfg_wdata write the module clock in hertz; change it only while idle.
//   Request beat: baud_rate on req_valid, held back by req_stall.
//   Result beat: status on res_valid, held back by res_stall.
//   Status: 0 ok, 1 zero rate, 2 divisor zero or above 0x1FFF, 3 error above 3 %.
// Timing
//   One request per clock while req_stall is low. A result shows on res_valid
//   after its request is taken and has passed 32 stages of the 2*clock/baud
//   divider (one quotient bit each), one range stage, 32 stages of the
//   achieved-rate divider and two stages of error check, then the output register.
// Reset
//   Clears every valid bit and sets the module clock to 120 MHz.
// Stall
//   The output register holds its beat while res_stall is high; the pipeline
//   keeps moving until a valid beat reaches its last stage behind a held
//   output, and only then is req_stall raised.
`default_nettype none

module uart_baud_divisor_calc
	import ubdc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CLK_W-1:0]  cfg_wdata,
	input  wire logic              req_valid,
	output      logic              req_stall,
	input  wire logic [BAUD_W-1:0] baud_rate,
	output      logic              res_valid,
	input  wire logic              res_stall,
	output      logic [1:0]        status
);

	logic [CLK_W-1:0] clk_hz_q;
	logic             adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLK_RESET;
		end else if (cfg_we) begin
			clk_hz_q <= cfg_wdata;
		end
	end

	// ---- first divider: 2*clock / baud, stages 1..32
	pkt_t             in_pkt;
	logic [NUM_W-1:0] a_v_s;
	pkt_t             a_pkt_s [NUM_W];
	logic [BAUD_W-1:0] a_rem_s [NUM_W];
	logic [NUM_W-1:0]  a_q_s   [NUM_W];
	logic [BAUD_W-1:0] a_rem_d [NUM_W];
	logic [NUM_W-1:0]  a_q_d   [NUM_W];

	assign in_pkt.baud = baud_rate;
	assign in_pkt.num  = {clk_hz_q, 1'b0};

	for (genvar k = 0; k < NUM_W; k++) begin : g_div_a
		pkt_t              src_pkt;
		logic [BAUD_W-1:0] src_rem;
		logic [NUM_W-1:0]  src_q;
		logic [BAUD_W:0]   step;
		if (k == 0) begin : g_first
			assign src_pkt = in_pkt;
			assign src_rem = '0;
			assign src_q   = '0;
		end else begin : g_next
			assign src_pkt = a_pkt_s[k-1];
			assign src_rem = a_rem_s[k-1];
			assign src_q   = a_q_s[k-1];
		end
		assign step       = div_step_a(src_rem, src_pkt.num[NUM_W-1-k], src_pkt.baud);
		assign a_rem_d[k] = step[BAUD_W-1:0];
		assign a_q_d[k]   = {src_q[NUM_W-2:0], step[BAUD_W]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_pkt_s[0] <= in_pkt;
			for (int k = 1; k < NUM_W; k++) begin
				a_pkt_s[k] <= a_pkt_s[k-1];
			end
			for (int k = 0; k < NUM_W; k++) begin
				a_rem_s[k] <= a_rem_d[k];
				a_q_s[k]   <= a_q_d[k];
			end
		end
	end

	// ---- stage 33: split into SBR and BRFA and check the divisor range
	logic [SBR_W-1:0] sbr;
	flag_t            flags_d;
	logic             v_s33;
	pkt_t             pkt_s33;
	logic [DEN_W-1:0] den_s33;
	flag_t            flags_s33;

	assign sbr               = a_q_s[NUM_W-1][NUM_W-1:FRAC_W];
	assign flags_d.zero_baud = (a_pkt_s[NUM_W-1].baud == '0);
	assign flags_d.range_bad = (sbr == '0) || (sbr > DIV_MAX);

	always_ff @(posedge clk) begin
		if (adv) begin
			pkt_s33   <= a_pkt_s[NUM_W-1];
			den_s33   <= a_q_s[NUM_W-1][DEN_W-1:0];
			flags_s33 <= flags_d;
		end
	end

	// ---- second divider: 2*clock / (32*SBR + BRFA), stages 34..65
	logic [NUM_W-1:0] b_v_s;
	pkt_t             b_pkt_s   [NUM_W];
	logic [DEN_W-1:0] b_den_s   [NUM_W];
	flag_t            b_flags_s [NUM_W];
	logic [DEN_W-1:0] b_rem_s   [NUM_W];
	logic [NUM_W-1:0] b_q_s     [NUM_W];
	logic [DEN_W-1:0] b_rem_d   [NUM_W];
	logic [NUM_W-1:0] b_q_d     [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_div_b
		pkt_t             src_pkt;
		logic [DEN_W-1:0] src_den;
		logic [DEN_W-1:0] src_rem;
		logic [NUM_W-1:0] src_q;
		logic [DEN_W:0]   step;
		if (k == 0) begin : g_first
			assign src_pkt = pkt_s33;
			assign src_den = den_s33;
			assign src_rem = '0;
			assign src_q   = '0;
		end else begin : g_next
			assign src_pkt = b_pkt_s[k-1];
			assign src_den = b_den_s[k-1];
			assign src_rem = b_rem_s[k-1];
			assign src_q   = b_q_s[k-1];
		end
		assign step       = div_step_b(src_rem, src_pkt.num[NUM_W-1-k], src_den);
		assign b_rem_d[k] = step[DEN_W-1:0];
		assign b_q_d[k]   = {src_q[NUM_W-2:0], step[DEN_W]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_pkt_s[0]   <= pkt_s33;
			b_den_s[0]   <= den_s33;
			b_flags_s[0] <= flags_s33;
			for (int k = 1; k < NUM_W; k++) begin
				b_pkt_s[k]   <= b_pkt_s[k-1];
				b_den_s[k]   <= b_den_s[k-1];
				b_flags_s[k] <= b_flags_s[k-1];
			end
			for (int k = 0; k < NUM_W; k++) begin
				b_rem_s[k] <= b_rem_d[k];
				b_q_s[k]   <= b_q_d[k];
			end
		end
	end

	// ---- stages 66..67: error against the limit
	status_t chk_status;
	logic    v_s66;
	logic    v_s67;

	ubdc_err_check u_err_check (
		.clk      (clk),
		.en       (adv),
		.baud     (b_pkt_s[NUM_W-1].baud),
		.achieved (b_q_s[NUM_W-1]),
		.flags    (b_flags_s[NUM_W-1]),
		.status   (chk_status)
	);

	// ---- valid bits travel with the beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_s <= '0;
			v_s33 <= 1'b0;
			b_v_s <= '0;
			v_s66 <= 1'b0;
			v_s67 <= 1'b0;
		end else if (adv) begin
			a_v_s <= {a_v_s[NUM_W-2:0], req_valid};
			v_s33 <= a_v_s[NUM_W-1];
			b_v_s <= {b_v_s[NUM_W-2:0], v_s33};
			v_s66 <= b_v_s[NUM_W-1];
			v_s67 <= v_s66;
		end
	end

	// ---- output register
	logic    res_valid_q;
	status_t status_q;
	logic    out_load;

	assign out_load  = !res_valid_q || !res_stall;
	assign adv       = !(v_s67 && res_valid_q && res_stall);
	assign req_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= v_s67;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= chk_status;
		end
	end

	assign res_valid = res_valid_q;
	assign status    = status_q;

	// ---- checks
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (res_valid_q && res_stall && v_s67))
		else $error("request stalled without a held result behind a full last stage");

	a_last_beat_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s67 && adv) |=> res_valid_q)
		else $error("beat from last stage not taken into output register");

	a_div_a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(a_v_s[NUM_W-1] && a_pkt_s[NUM_W-1].baud != '0)
			|-> (a_rem_s[NUM_W-1] < a_pkt_s[NUM_W-1].baud))
		else $error("first divider remainder not below the rate");

	a_div_b_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(b_v_s[NUM_W-1] && !b_flags_s[NUM_W-1].zero_baud && !b_flags_s[NUM_W-1].range_bad)
			|-> (b_rem_s[NUM_W-1] < b_den_s[NUM_W-1]))
		else $error("second divider remainder not below its divisor");

endmodule

`default_nettype wire
